>>> design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, widths and codes of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int MAX_SLOTS_DEF = 128;
	localparam int SLOT_CAP      = 256;

	localparam int KEY_W    = 20;
	localparam int QTY_W    = 16;
	localparam int MONEY_W  = 20;
	localparam int SIZE_W   = 8;
	localparam int STATUS_W = 3;
	localparam int PROBE_W  = 8;
	localparam int TOTAL_W  = 36;
	localparam int PROFIT_W = 37;

	localparam int MOD_BITS  = 4;
	localparam int MOD_STEPS = KEY_W / MOD_BITS;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_TABLE_SIZE = 1'b0;

	localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 8'd128;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_ORDER  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_ORDERED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_NO_STOCK  = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [QTY_W-1:0]   stock;
		logic [MONEY_W-1:0] cost;
		logic [MONEY_W-1:0] price;
	} entry_t;

	typedef struct packed {
		logic    load;
		logic    init_probe;
		logic    advance;
		logic    set_result;
		status_t res_status;
		logic    mul_total;
		logic    mul_profit;
		logic    wr;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic mod_done;
		logic op;
		logic empty;
		logic match;
		logic last;
		logic short_stock;
	} stat_t;

endpackage

>>> design/lpht_mod.sv
// ----------------------------------------------------------------------------
// lpht_mod
// Iterative remainder unit: key mod size, four dividend bits per cycle.
// ----------------------------------------------------------------------------
module lpht_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lpht_pkg::KEY_W-1:0]  dividend,
	input  logic [lpht_pkg::SIZE_W-1:0] divisor,
	output logic                        done,
	output logic [lpht_pkg::SIZE_W-1:0] rem
);

	logic [lpht_pkg::KEY_W-1:0]     dvd_q;
	logic [lpht_pkg::SIZE_W-1:0]    rem_q;
	logic [lpht_pkg::MOD_CNT_W-1:0] step_q;
	logic                           busy_q;
	logic                           done_q;
	logic [lpht_pkg::SIZE_W-1:0]    rem_nxt;

	always_comb begin
		logic [lpht_pkg::SIZE_W:0] r;
		rem_nxt = rem_q;
		for (int i = 0; i < lpht_pkg::MOD_BITS; i++) begin
			r = {rem_nxt, dvd_q[lpht_pkg::KEY_W-1-i]};
			if (r >= {1'b0, divisor}) begin
				r = r - {1'b0, divisor};
			end
			rem_nxt = r[lpht_pkg::SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << lpht_pkg::MOD_BITS;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> design/lpht_dp.sv
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: item registers, slot memory, probe walk, money arithmetic and
// output registers.
// ----------------------------------------------------------------------------
module lpht_dp #(
	parameter int DEPTH = lpht_pkg::MAX_SLOTS_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lpht_pkg::cmd_t                       cmd,
	output lpht_pkg::stat_t                      stat,
	input  logic [lpht_pkg::SIZE_W-1:0]          n_eff,
	input  logic                                 op,
	input  logic [lpht_pkg::KEY_W-1:0]           book_id,
	input  logic [lpht_pkg::QTY_W-1:0]           quantity,
	input  logic [lpht_pkg::MONEY_W-1:0]         cost_cents,
	input  logic [lpht_pkg::MONEY_W-1:0]         price_cents,
	output logic [lpht_pkg::STATUS_W-1:0]        status,
	output logic [lpht_pkg::PROBE_W-1:0]         probes,
	output logic [lpht_pkg::QTY_W-1:0]           stock_left,
	output logic [lpht_pkg::TOTAL_W-1:0]         order_total,
	output logic signed [lpht_pkg::PROFIT_W-1:0] order_profit
);

	logic                                 op_q;
	logic [lpht_pkg::KEY_W-1:0]           key_q;
	logic [lpht_pkg::QTY_W-1:0]           qty_q;
	logic [lpht_pkg::MONEY_W-1:0]         cost_q;
	logic [lpht_pkg::MONEY_W-1:0]         price_q;

	logic [IDX_W-1:0]                     idx_q;
	logic [lpht_pkg::PROBE_W-1:0]         count_q;
	logic [lpht_pkg::PROBE_W:0]           idx_inc;

	lpht_pkg::entry_t                     mem_q [DEPTH];
	logic [DEPTH-1:0]                     valid_q;
	lpht_pkg::entry_t                     rd_q;
	logic                                 vld_rd_q;
	lpht_pkg::entry_t                     wdata;

	lpht_pkg::status_t                    res_status_q;
	logic [lpht_pkg::PROBE_W-1:0]         res_probes_q;
	logic [lpht_pkg::QTY_W-1:0]           res_stock_q;
	logic [lpht_pkg::TOTAL_W-1:0]         res_total_q;
	logic signed [lpht_pkg::PROFIT_W-1:0] res_profit_q;
	logic [lpht_pkg::QTY_W-1:0]           res_stock_nxt;
	logic signed [lpht_pkg::PROFIT_W-1:0] profit_nxt;

	logic [lpht_pkg::STATUS_W-1:0]        status_q;
	logic [lpht_pkg::PROBE_W-1:0]         probes_q;
	logic [lpht_pkg::QTY_W-1:0]           stock_q;
	logic [lpht_pkg::TOTAL_W-1:0]         total_q;
	logic signed [lpht_pkg::PROFIT_W-1:0] profit_q;

	logic                                 mod_done;
	logic [lpht_pkg::SIZE_W-1:0]          home;
	logic signed [lpht_pkg::MONEY_W:0]    margin;
	logic signed [lpht_pkg::QTY_W:0]      qty_s;

	lpht_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (book_id),
		.divisor  (n_eff),
		.done     (mod_done),
		.rem      (home)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			key_q   <= book_id;
			qty_q   <= quantity;
			cost_q  <= cost_cents;
			price_q <= price_cents;
		end
	end

	assign idx_inc = {{(lpht_pkg::PROBE_W + 1 - IDX_W){1'b0}}, idx_q}
		+ (lpht_pkg::PROBE_W + 1)'(1);

	always_ff @(posedge clk) begin
		if (cmd.init_probe) begin
			idx_q   <= home[IDX_W-1:0];
			count_q <= lpht_pkg::PROBE_W'(1);
		end else if (cmd.advance) begin
			idx_q   <= (idx_inc == {1'b0, n_eff}) ? '0 : idx_inc[IDX_W-1:0];
			count_q <= count_q + 1'b1;
		end
	end

	always_comb begin
		if (op_q == lpht_pkg::OP_INSERT) begin
			wdata = '{key: key_q, stock: qty_q, cost: cost_q, price: price_q};
		end else begin
			wdata = '{key: rd_q.key, stock: res_stock_q, cost: rd_q.cost, price: rd_q.price};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[idx_q] <= wdata;
		end
		rd_q <= mem_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (cmd.wr) begin
				valid_q[idx_q] <= 1'b1;
			end
			vld_rd_q <= valid_q[idx_q];
		end
	end

	assign stat.mod_done    = mod_done;
	assign stat.op          = op_q;
	assign stat.empty       = !vld_rd_q;
	assign stat.match       = vld_rd_q && (rd_q.key == key_q);
	assign stat.last        = (count_q == n_eff);
	assign stat.short_stock = (qty_q > rd_q.stock);

	always_comb begin
		unique case (cmd.res_status)
			lpht_pkg::ST_INSERTED: res_stock_nxt = qty_q;
			lpht_pkg::ST_ORDERED:  res_stock_nxt = rd_q.stock - qty_q;
			lpht_pkg::ST_NO_STOCK: res_stock_nxt = rd_q.stock;
			default:               res_stock_nxt = '0;
		endcase
	end

	assign margin     = $signed({1'b0, rd_q.price}) - $signed({1'b0, rd_q.cost});
	assign qty_s      = $signed({1'b0, qty_q});
	assign profit_nxt = margin * qty_s;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_total_q  <= '0;
			res_profit_q <= '0;
		end else begin
			if (cmd.mul_total) begin
				res_total_q <= rd_q.price * qty_q;
			end
			if (cmd.mul_profit) begin
				res_profit_q <= profit_nxt;
			end
		end
		if (cmd.set_result) begin
			res_status_q <= cmd.res_status;
			res_probes_q <= count_q;
			res_stock_q  <= res_stock_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= res_status_q;
			probes_q <= res_probes_q;
			stock_q  <= res_stock_q;
			total_q  <= res_total_q;
			profit_q <= res_profit_q;
		end
	end

	assign status       = status_q;
	assign probes       = probes_q;
	assign stock_left   = stock_q;
	assign order_total  = total_q;
	assign order_profit = profit_q;

endmodule

>>> design/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller: sequences remainder, probe walk, arithmetic, slot write and
// the output transaction.
// ----------------------------------------------------------------------------
module lpht_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  lpht_pkg::stat_t stat,
	output lpht_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_MOD    = 8'b0000_0010,
		S_PROBE  = 8'b0000_0100,
		S_CHECK  = 8'b0000_1000,
		S_MUL_T  = 8'b0001_0000,
		S_MUL_P  = 8'b0010_0000,
		S_WRITE  = 8'b0100_0000,
		S_RESP   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		cmd.res_status = lpht_pkg::ST_NOT_FOUND;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_MOD;
				end
			end
			S_MOD: begin
				if (stat.mod_done) begin
					cmd.init_probe = 1'b1;
					state_nxt      = S_PROBE;
				end
			end
			S_PROBE: begin
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				priority if (stat.empty || stat.match) begin
					cmd.set_result = 1'b1;
					priority if (stat.op == lpht_pkg::OP_INSERT) begin
						cmd.res_status = lpht_pkg::ST_INSERTED;
						state_nxt      = S_WRITE;
					end else if (stat.empty) begin
						cmd.res_status = lpht_pkg::ST_NOT_FOUND;
						state_nxt      = S_RESP;
					end else if (stat.short_stock) begin
						cmd.res_status = lpht_pkg::ST_NO_STOCK;
						state_nxt      = S_RESP;
					end else begin
						cmd.res_status = lpht_pkg::ST_ORDERED;
						state_nxt      = S_MUL_T;
					end
				end else if (stat.last) begin
					cmd.set_result = 1'b1;
					cmd.res_status = (stat.op == lpht_pkg::OP_INSERT) ?
						lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
					state_nxt      = S_RESP;
				end else begin
					cmd.advance = 1'b1;
					state_nxt   = S_PROBE;
				end
			end
			S_MUL_T: begin
				cmd.mul_total = 1'b1;
				state_nxt     = S_MUL_P;
			end
			S_MUL_P: begin
				cmd.mul_profit = 1'b1;
				state_nxt      = S_WRITE;
			end
			S_WRITE: begin
				cmd.wr    = 1'b1;
				state_nxt = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> design/linear_probe_hash_table.sv
// Each transaction passes the remainder unit, then a probe and a check per slot visited;
// a completed order adds the total and profit multiplies before its slot write.
// The next item is taken the cycle after its predecessor's result is registered.
// The slot read is registered, so each probe state is followed by its check state.
// Reset: table_size is 128 and every slot is empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing inventory table with linear probing, insert and order.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
	parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lpht_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [lpht_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [lpht_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic [lpht_pkg::KEY_W-1:0]           book_id,
	input  logic [lpht_pkg::QTY_W-1:0]           quantity,
	input  logic [lpht_pkg::MONEY_W-1:0]         cost_cents,
	input  logic [lpht_pkg::MONEY_W-1:0]         price_cents,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [lpht_pkg::STATUS_W-1:0]        status,
	output logic [lpht_pkg::PROBE_W-1:0]         probes,
	output logic [lpht_pkg::QTY_W-1:0]           stock_left,
	output logic [lpht_pkg::TOTAL_W-1:0]         order_total,
	output logic signed [lpht_pkg::PROFIT_W-1:0] order_profit
);

	// only slots below the 8-bit size are ever reached
	localparam int DEPTH = (MAX_SLOTS < lpht_pkg::SLOT_CAP) ? MAX_SLOTS : lpht_pkg::SLOT_CAP;
	localparam int IDX_W = $clog2(DEPTH);

	logic [lpht_pkg::SIZE_W-1:0] table_size_q;
	logic [lpht_pkg::SIZE_W-1:0] n_eff;
	logic                        reg_sel;
	lpht_pkg::cmd_t              cmd;
	lpht_pkg::stat_t             stat;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[lpht_pkg::APB_ADDR_W-1] == lpht_pkg::REG_TABLE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= lpht_pkg::TABLE_SIZE_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			table_size_q <= pwdata[lpht_pkg::SIZE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = lpht_pkg::APB_DATA_W'(table_size_q);
		end
	end

	always_comb begin
		priority if (table_size_q == '0) begin
			n_eff = lpht_pkg::SIZE_W'(1);
		end else if (32'(table_size_q) > MAX_SLOTS) begin
			n_eff = lpht_pkg::SIZE_W'(MAX_SLOTS);
		end else begin
			n_eff = table_size_q;
		end
	end

	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lpht_dp #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.n_eff        (n_eff),
		.op           (op),
		.book_id      (book_id),
		.quantity     (quantity),
		.cost_cents   (cost_cents),
		.price_cents  (price_cents),
		.status       (status),
		.probes       (probes),
		.stock_left   (stock_left),
		.order_total  (order_total),
		.order_profit (order_profit)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a transaction is in progress");

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (probes != '0) && (probes <= n_eff))
		else $error("probe count outside the used slots");

	a_money_only_on_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != lpht_pkg::ST_ORDERED) |-> (order_total == '0)
			&& (order_profit == '0))
		else $error("money reported on a transaction that is not an order");

	a_single_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid && !cmd.out_load)
		else $error("result register loaded twice in a row");

endmodule
